@@ hdl/x10tx_pkg.sv @@
package x10tx_pkg;

	localparam int GAP_CROSSINGS_DEF  = 6;
	localparam int BURSTS_PER_BIT_DEF = 3;

	// wide enough for 2 * BURSTS_PER_BIT - 1 over the whole range 1..7
	localparam int HALF_W = 4;

	localparam logic [4:0] SLOTS_PER_FRAME = 5'd22;
	localparam logic [4:0] START_SLOTS     = 5'd4;
	localparam logic [4:0] HOUSE_END       = 5'd12;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_WAIT  = 2'd1;
	localparam logic [1:0] MODE_BURST = 2'd2;
	localparam logic [1:0] MODE_GAP   = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_CODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_CODE    = 2'd3;

	localparam logic [3:0]  START_CODE_RST  = 4'd14;
	localparam logic [15:0] BURST_TICKS_RST = 16'd1000;
	localparam logic [4:0]  BRIGHT_CODE_RST = 5'd11;
	localparam logic [4:0]  DIM_CODE_RST    = 5'd9;

	typedef struct packed {
		logic [3:0]  start_code;
		logic [15:0] burst_ticks;
		logic [4:0]  bright_code;
		logic [4:0]  dim_code;
	} cfg_t;

	typedef struct packed {
		logic       send_request;
		logic [3:0] house_code;
		logic [4:0] key_code;
		logic [3:0] repeat_count;
		logic       zero_cross_level;
	} req_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [4:0]        slot_index;
		logic [HALF_W-1:0] burst_half;
		logic [15:0]       tick_count;
		logic [3:0]        repeats_left;
		logic [2:0]        gap_crossings_left;
		logic [3:0]        latched_house;
		logic [4:0]        latched_key;
		logic              wait_level;
		logic              tx_level;
	} state_t;

	function automatic logic slot_bit(input logic [4:0] s, input logic [3:0] sc,
			input logic [3:0] hc, input logic [4:0] kc);
		logic [4:0] p;
		logic [2:0] ki;
		logic       r;
		p  = '0;
		ki = '0;
		r  = 1'b0;
		if (s < START_SLOTS) begin
			r = sc[2'd3 - s[1:0]];
		end else if (s < HOUSE_END) begin
			p = s - START_SLOTS;
			r = hc[2'd3 - p[2:1]] ^ p[0];
		end else if (s < SLOTS_PER_FRAME) begin
			p  = s - HOUSE_END;
			ki = 3'd4 - p[3:1];
			r  = kc[ki] ^ p[0];
		end
		return r;
	endfunction

endpackage

@@ hdl/x10tx_if.sv @@
interface x10tx_in_if;
	logic       valid;
	logic       ready;
	logic       send_request;
	logic [3:0] house_code;
	logic [4:0] key_code;
	logic [3:0] repeat_count;
	logic       zero_cross_level;

	modport source (output valid, send_request, house_code, key_code, repeat_count,
		zero_cross_level, input ready);
	modport sink (input valid, send_request, house_code, key_code, repeat_count,
		zero_cross_level, output ready);
endinterface

interface x10tx_out_if;
	logic valid;
	logic ready;
	logic tx_out;
	logic busy_res;

	modport source (output valid, tx_out, busy_res, input ready);
	modport sink (input valid, tx_out, busy_res, output ready);
endinterface

@@ hdl/x10tx_step.sv @@
module x10tx_step #(
	parameter int GAP_CROSSINGS  = x10tx_pkg::GAP_CROSSINGS_DEF,
	parameter int BURSTS_PER_BIT = x10tx_pkg::BURSTS_PER_BIT_DEF
) (
	input  x10tx_pkg::state_t cur,
	input  x10tx_pkg::cfg_t   cfg,
	input  x10tx_pkg::req_t   req,
	output x10tx_pkg::state_t nxt
);

	localparam int HW = x10tx_pkg::HALF_W;
	localparam logic [HW:0] HALF_END = (HW+1)'(2 * BURSTS_PER_BIT);

	logic [15:0] limit;
	logic [HW:0] half_inc;
	logic [4:0]  slot_inc;
	logic [3:0]  rep_dec;
	logic [2:0]  gap_dec;
	logic        lvl;
	logic        bit_now;
	logic        no_gap;

	assign lvl      = req.zero_cross_level;
	assign limit    = (cfg.burst_ticks == 16'd0) ? 16'd1 : cfg.burst_ticks;
	assign half_inc = {1'b0, cur.burst_half} + 1'b1;
	assign slot_inc = cur.slot_index + 5'd1;
	assign rep_dec  = cur.repeats_left - 4'd1;
	assign gap_dec  = (cur.gap_crossings_left != 3'd0) ? cur.gap_crossings_left - 3'd1 : 3'd0;
	assign bit_now  = x10tx_pkg::slot_bit(cur.slot_index, cfg.start_code,
		cur.latched_house, cur.latched_key);
	assign no_gap   = (cur.latched_key == cfg.bright_code) || (cur.latched_key == cfg.dim_code);

	always_comb begin
		nxt = cur;
		case (cur.mode)
			x10tx_pkg::MODE_IDLE: begin
				if (req.send_request) begin
					nxt.latched_house = req.house_code;
					nxt.latched_key   = req.key_code;
					nxt.repeats_left  = req.repeat_count;
					nxt.tx_level      = 1'b0;
					if (req.repeat_count != 4'd0) begin
						nxt.slot_index = '0;
						nxt.mode       = x10tx_pkg::MODE_WAIT;
						nxt.wait_level = lvl;
					end
				end
			end
			x10tx_pkg::MODE_WAIT: begin
				if (lvl != cur.wait_level) begin
					nxt.mode       = x10tx_pkg::MODE_BURST;
					nxt.burst_half = '0;
					nxt.tick_count = 16'd1;
					nxt.tx_level   = bit_now;
				end
			end
			x10tx_pkg::MODE_BURST: begin
				if (cur.tick_count >= limit) begin
					nxt.burst_half = half_inc[HW-1:0];
					nxt.tick_count = 16'd1;
					if (half_inc >= HALF_END) begin
						nxt.burst_half = '0;
						nxt.tick_count = '0;
						nxt.tx_level   = 1'b0;
						if (slot_inc < x10tx_pkg::SLOTS_PER_FRAME) begin
							nxt.slot_index = slot_inc;
							nxt.mode       = x10tx_pkg::MODE_WAIT;
							nxt.wait_level = lvl;
						end else begin
							nxt.slot_index   = '0;
							nxt.repeats_left = rep_dec;
							if (!no_gap) begin
								nxt.mode               = x10tx_pkg::MODE_GAP;
								nxt.gap_crossings_left = 3'(GAP_CROSSINGS);
								nxt.wait_level         = lvl;
							end else if (rep_dec != 4'd0) begin
								nxt.mode       = x10tx_pkg::MODE_WAIT;
								nxt.wait_level = lvl;
							end else begin
								nxt.mode = x10tx_pkg::MODE_IDLE;
							end
						end
					end else begin
						nxt.tx_level = half_inc[0] ? 1'b0 : bit_now;
					end
				end else begin
					nxt.tick_count = cur.tick_count + 16'd1;
				end
			end
			default: begin
				if (lvl != cur.wait_level) begin
					nxt.wait_level         = lvl;
					nxt.gap_crossings_left = gap_dec;
					if (gap_dec == 3'd0) begin
						if (cur.repeats_left != 4'd0) begin
							nxt.slot_index = '0;
							nxt.mode       = x10tx_pkg::MODE_WAIT;
						end else begin
							nxt.mode = x10tx_pkg::MODE_IDLE;
						end
					end
				end
			end
		endcase
	end

endmodule

@@ hdl/x10_powerline_transmitter_top.sv @@
// channel  | dir | handshake     | payload
// in_ch    | in  | valid / ready | send_request, house_code, key_code, repeat_count,
//          |     |               | zero_cross_level
// out_ch   | out | valid / ready | tx_out, busy_res
// cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// one input transfer per cycle unless the result stalls; each transfer is one tick
// and yields one result; the sequencer state advances in a single registered step
// per transfer; the result register holds the state after that step; a new transfer
// is taken whenever the result register is empty or is being taken in the same cycle
// arst_n clears the sequencer to idle and loads the register defaults
module x10_powerline_transmitter_top #(
	parameter int GAP_CROSSINGS  = x10tx_pkg::GAP_CROSSINGS_DEF,
	parameter int BURSTS_PER_BIT = x10tx_pkg::BURSTS_PER_BIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	x10tx_in_if.sink                            in_ch,
	x10tx_out_if.source                         out_ch,
	input  logic                                cfg_we,
	input  logic [x10tx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [x10tx_pkg::CFG_DATA_W-1:0]    cfg_data
);

	x10tx_pkg::state_t state_q;
	x10tx_pkg::state_t state_nxt;
	x10tx_pkg::cfg_t   cfg_q;
	x10tx_pkg::req_t   req;
	logic              out_valid_q;
	logic              accept;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign req.send_request     = in_ch.send_request;
	assign req.house_code       = in_ch.house_code;
	assign req.key_code         = in_ch.key_code;
	assign req.repeat_count     = in_ch.repeat_count;
	assign req.zero_cross_level = in_ch.zero_cross_level;

	x10tx_step #(
		.GAP_CROSSINGS  (GAP_CROSSINGS),
		.BURSTS_PER_BIT (BURSTS_PER_BIT)
	) u_step (
		.cur (state_q),
		.cfg (cfg_q),
		.req (req),
		.nxt (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code  <= x10tx_pkg::START_CODE_RST;
			cfg_q.burst_ticks <= x10tx_pkg::BURST_TICKS_RST;
			cfg_q.bright_code <= x10tx_pkg::BRIGHT_CODE_RST;
			cfg_q.dim_code    <= x10tx_pkg::DIM_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				x10tx_pkg::REG_START_CODE:  cfg_q.start_code  <= cfg_data[3:0];
				x10tx_pkg::REG_BURST_TICKS: cfg_q.burst_ticks <= cfg_data[15:0];
				x10tx_pkg::REG_BRIGHT_CODE: cfg_q.bright_code <= cfg_data[4:0];
				x10tx_pkg::REG_DIM_CODE:    cfg_q.dim_code    <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.tx_out   = state_q.tx_level;
	assign out_ch.busy_res = (state_q.mode != x10tx_pkg::MODE_IDLE);

endmodule

@@ hdl/x10tx_checker.sv @@
module x10tx_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic tx_out,
	input logic busy_res
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_out) && $stable(busy_res))
		else $error("result changed while stalled");

	// input side only waits on a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !out_ready) |-> in_ready)
		else $error("input stalled without a stalled result");

	// every input transfer gives a result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("input transfer without result");

	// no result appears without an input transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready) |=> !out_valid)
		else $error("result without input transfer");

	// carrier only while a transmission runs
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_out |-> busy_res)
		else $error("carrier active while idle");

endmodule

bind x10_powerline_transmitter_top x10tx_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.tx_out    (out_ch.tx_out),
	.busy_res  (out_ch.busy_res)
);
